// File: hw/rtl/i2cms_pkg.sv
// ----------------------------------------------------------------------------
// i2cms_pkg: shared types and constants for the I2C master bit sequencer
// Command codes, the queued step record and the last-step index per command.
// ----------------------------------------------------------------------------
package i2cms_pkg;

   typedef enum logic [2:0] {
      CMD_NONE      = 3'd0,
      CMD_START     = 3'd1,
      CMD_STOP      = 3'd2,
      CMD_SEND_BYTE = 3'd3,
      CMD_RECV_BYTE = 3'd4,
      CMD_SEND_ACK  = 3'd5,
      CMD_RECV_ACK  = 3'd6
   } cmd_type;

   // one classified pin step, as it waits in the queue
   typedef struct packed {
      cmd_type     cmd;
      logic [7:0]  tx_byte;
      logic        ack_bit;
      logic        sda_in;
   } item_type;

   localparam int unsigned QUEUE_DEPTH = 2;
   localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int unsigned STEP_W = 5;

   // index of the final step of each command
   localparam logic [STEP_W-1:0] START_LAST     = 5'd3;
   localparam logic [STEP_W-1:0] STOP_LAST      = 5'd2;
   localparam logic [STEP_W-1:0] SEND_ACK_LAST  = 5'd2;
   localparam logic [STEP_W-1:0] SEND_BYTE_LAST = 5'd23;
   localparam logic [STEP_W-1:0] RECV_ACK_LAST  = 5'd3;
   localparam logic [STEP_W-1:0] RECV_BYTE_LAST = 5'd24;

   // phase within one bit slot: send is data, clock high, clock low; receive is clock high, sample, clock low
   localparam logic [1:0] PH_FIRST  = 2'd0;
   localparam logic [1:0] PH_SECOND = 2'd1;
   localparam logic [1:0] PH_THIRD  = 2'd2;

endpackage

// File: hw/rtl/i2c_master_bit_sequencer.sv
// ----------------------------------------------------------------------------
// i2c_master_bit_sequencer: I2C master pin step sequencer
// Each request transfer is one pin step; each step yields one response transfer
// with the line levels, progress flags and receive registers after that step.
// ----------------------------------------------------------------------------
//
//  channel | ports  | direction | carries
//  --------+--------+-----------+------------------------------------------------
//  request | req_*  | in        | operation, tx_byte, ack_bit, sampled SDA
//  respond | rsp_*  | out       | scl, sda, busy, done, rx_byte, rx_ack, rejected
//
//  One step per cycle while rsp_ready stays high; a step's response follows its request
//  transfer through classify, the 2-entry queue and the sequencer's response register.
//  Reset: lines released high, no command active, rx_ack reads 1.
//  A stalled response holds the sequencer; the queue keeps taking requests until
//  it holds two steps. With back-to-back requests it holds one, so req_ready
//  drops the cycle after rsp_ready does.
//
module i2c_master_bit_sequencer (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [2:0] req_operation,
   input  logic [7:0] req_tx_byte,
   input  logic       req_ack_bit,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic       rsp_scl,
   output logic       rsp_sda,
   output logic       rsp_busy_res,
   output logic       rsp_done_res,
   output logic [7:0] rsp_rx_byte,
   output logic       rsp_rx_ack,
   output logic       rsp_rejected
);
   import i2cms_pkg::*;

   item_type  front_item;
   item_type  head_item;
   logic      q_full;
   logic      q_not_empty;
   logic      q_pop;
   logic      q_push;

   // front: classify the request
   i2cms_front u_front (
      .operation (req_operation),
      .tx_byte   (req_tx_byte),
      .ack_bit   (req_ack_bit),
      .sda_in    (req_sda_in),
      .item      (front_item)
   );

   assign req_ready = !q_full;
   assign q_push    = req_valid && !q_full;

   // short queue decouples request acceptance from response stalls
   i2cms_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_item (front_item),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .head      (head_item)
   );

   // back: play the step, update line state, register the response
   i2cms_back u_back (
      .clock        (clock),
      .reset        (reset),
      .item_valid   (q_not_empty),
      .item         (head_item),
      .item_pop     (q_pop),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_scl      (rsp_scl),
      .rsp_sda      (rsp_sda),
      .rsp_busy_res (rsp_busy_res),
      .rsp_done_res (rsp_done_res),
      .rsp_rx_byte  (rsp_rx_byte),
      .rsp_rx_ack   (rsp_rx_ack),
      .rsp_rejected (rsp_rejected)
   );

endmodule

// File: hw/rtl/i2cms_front.sv
// ----------------------------------------------------------------------------
// i2cms_front: request classifier
// Decodes the operation field into a command code; unused codes mean no command.
// ----------------------------------------------------------------------------
module i2cms_front (
   input  logic [2:0]          operation,
   input  logic [7:0]          tx_byte,
   input  logic                ack_bit,
   input  logic                sda_in,
   output i2cms_pkg::item_type item
);
   import i2cms_pkg::*;

   cmd_type cmd;

   always_comb begin
      unique case (operation)
         CMD_START:     cmd = CMD_START;
         CMD_STOP:      cmd = CMD_STOP;
         CMD_SEND_BYTE: cmd = CMD_SEND_BYTE;
         CMD_RECV_BYTE: cmd = CMD_RECV_BYTE;
         CMD_SEND_ACK:  cmd = CMD_SEND_ACK;
         CMD_RECV_ACK:  cmd = CMD_RECV_ACK;
         default:       cmd = CMD_NONE;
      endcase
   end

   assign item.cmd     = cmd;
   assign item.tx_byte = tx_byte;
   assign item.ack_bit = ack_bit;
   assign item.sda_in  = sda_in;

endmodule

// File: hw/rtl/i2cms_queue.sv
// ----------------------------------------------------------------------------
// i2cms_queue: short step queue
// Register FIFO between classifier and sequencer; push and pop can happen in the same cycle.
// ----------------------------------------------------------------------------
module i2cms_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  i2cms_pkg::item_type push_item,
   output logic                full,
   input  logic                pop,
   output logic                not_empty,
   output i2cms_pkg::item_type head
);
   import i2cms_pkg::*;

   item_type            mem_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: hw/rtl/i2cms_back.sv
// ----------------------------------------------------------------------------
// i2cms_back: pin step sequencer with result register
// Plays one step of the active command per queued item and registers the result.
// ----------------------------------------------------------------------------
module i2cms_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                item_valid,
   input  i2cms_pkg::item_type item,
   output logic                item_pop,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic                rsp_scl,
   output logic                rsp_sda,
   output logic                rsp_busy_res,
   output logic                rsp_done_res,
   output logic [7:0]          rsp_rx_byte,
   output logic                rsp_rx_ack,
   output logic                rsp_rejected
);
   import i2cms_pkg::*;

   // sequencer state
   cmd_type             active_ff, active_in;
   logic [STEP_W-1:0]   step_ff, step_in;
   logic [1:0]          phase_ff, phase_in;
   logic [2:0]          bit_ff, bit_in;
   logic [7:0]          tx_ff, tx_in;
   logic                ack_send_ff, ack_send_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic [7:0]          rx_ff, rx_in;
   logic                ack_rx_ff, ack_rx_in;

   // result register
   logic                valid_ff, valid_in;
   logic                busy_ff, busy_in;
   logic                done_ff, done_in;
   logic                rej_ff, rej_in;

   // working values for this step
   logic                launch;
   cmd_type             cur_cmd;
   logic [STEP_W-1:0]   cur_step;
   logic [1:0]          cur_phase;
   logic [2:0]          cur_bit;
   logic [7:0]          cur_tx;
   logic                cur_ack;
   logic                last;

   assign item_pop = item_valid && (!valid_ff || rsp_ready);

   always_comb begin
      launch    = (active_ff == CMD_NONE) && (item.cmd != CMD_NONE);
      cur_cmd   = launch ? item.cmd     : active_ff;
      cur_step  = launch ? '0           : step_ff;
      cur_phase = launch ? PH_FIRST     : phase_ff;
      cur_bit   = launch ? 3'd0         : bit_ff;
      cur_tx    = launch ? item.tx_byte : tx_ff;
      cur_ack   = launch ? item.ack_bit : ack_send_ff;

      scl_in    = scl_ff;
      sda_in    = sda_ff;
      rx_in     = rx_ff;
      ack_rx_in = ack_rx_ff;
      last      = 1'b0;

      unique case (cur_cmd)
         CMD_NONE: begin
            last = 1'b0;
         end
         CMD_START: begin
            case (cur_step)
               5'd0:    sda_in = 1'b1;
               5'd1:    scl_in = 1'b1;
               5'd2:    sda_in = 1'b0;
               default: scl_in = 1'b0;
            endcase
            last = (cur_step >= START_LAST);
         end
         CMD_STOP: begin
            case (cur_step)
               5'd0:    sda_in = 1'b0;
               5'd1:    scl_in = 1'b1;
               default: sda_in = 1'b1;
            endcase
            last = (cur_step >= STOP_LAST);
         end
         CMD_SEND_ACK: begin
            case (cur_step)
               5'd0:    sda_in = cur_ack;
               5'd1:    scl_in = 1'b1;
               default: scl_in = 1'b0;
            endcase
            last = (cur_step >= SEND_ACK_LAST);
         end
         CMD_SEND_BYTE: begin
            case (cur_phase)
               PH_FIRST:  sda_in = cur_tx[~cur_bit];
               PH_SECOND: scl_in = 1'b1;
               default:   scl_in = 1'b0;
            endcase
            last = (cur_step >= SEND_BYTE_LAST);
         end
         CMD_RECV_ACK: begin
            case (cur_step)
               5'd0:    sda_in    = 1'b1;
               5'd1:    scl_in    = 1'b1;
               5'd2:    ack_rx_in = item.sda_in;
               default: scl_in    = 1'b0;
            endcase
            last = (cur_step >= RECV_ACK_LAST);
         end
         CMD_RECV_BYTE: begin
            if (cur_step == '0) begin
               sda_in = 1'b1;
               rx_in  = '0;
            end else begin
               case (cur_phase)
                  PH_FIRST: scl_in = 1'b1;
                  PH_SECOND: begin
                     if (item.sda_in) begin
                        rx_in[~cur_bit] = 1'b1;
                     end
                  end
                  default: scl_in = 1'b0;
               endcase
            end
            last = (cur_step >= RECV_BYTE_LAST);
         end
         default: begin
            last = 1'b1;
         end
      endcase

      // step bookkeeping; the receive byte prologue step does not open a bit slot
      tx_in       = cur_tx;
      ack_send_in = cur_ack;
      busy_in     = 1'b0;
      done_in     = 1'b0;
      rej_in      = (active_ff != CMD_NONE) && (item.cmd != CMD_NONE);
      if (cur_cmd == CMD_NONE) begin
         active_in = CMD_NONE;
         step_in   = cur_step;
         phase_in  = cur_phase;
         bit_in    = cur_bit;
      end else if (last) begin
         active_in = CMD_NONE;
         step_in   = '0;
         phase_in  = PH_FIRST;
         bit_in    = 3'd0;
         done_in   = 1'b1;
      end else begin
         active_in = cur_cmd;
         step_in   = cur_step + 1'b1;
         busy_in   = 1'b1;
         if ((cur_cmd == CMD_RECV_BYTE) && (cur_step == '0)) begin
            phase_in = PH_FIRST;
            bit_in   = 3'd0;
         end else if (cur_phase == PH_THIRD) begin
            phase_in = PH_FIRST;
            bit_in   = cur_bit + 1'b1;
         end else begin
            phase_in = cur_phase + 1'b1;
            bit_in   = cur_bit;
         end
      end

      if (item_pop) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff   <= CMD_NONE;
         step_ff     <= '0;
         phase_ff    <= PH_FIRST;
         bit_ff      <= 3'd0;
         tx_ff       <= '0;
         ack_send_ff <= 1'b0;
         scl_ff      <= 1'b1;
         sda_ff      <= 1'b1;
         rx_ff       <= '0;
         ack_rx_ff   <= 1'b1;
         valid_ff    <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (item_pop) begin
            active_ff   <= active_in;
            step_ff     <= step_in;
            phase_ff    <= phase_in;
            bit_ff      <= bit_in;
            tx_ff       <= tx_in;
            ack_send_ff <= ack_send_in;
            scl_ff      <= scl_in;
            sda_ff      <= sda_in;
            rx_ff       <= rx_in;
            ack_rx_ff   <= ack_rx_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (item_pop) begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         rej_ff  <= rej_in;
      end
   end

   assign rsp_valid    = valid_ff;
   assign rsp_scl      = scl_ff;
   assign rsp_sda      = sda_ff;
   assign rsp_busy_res = busy_ff;
   assign rsp_done_res = done_ff;
   assign rsp_rx_byte  = rx_ff;
   assign rsp_rx_ack   = ack_rx_ff;
   assign rsp_rejected = rej_ff;

endmodule
